>>> src/fcs_pkg.sv
// Package for the flash command sequencer: beat types, command codes and flash geometry.
package fcs_pkg;

  // Flash geometry
  localparam int unsigned FLASH_BYTES = 524288;
  localparam int unsigned PAGE_BYTES  = 16384;
  localparam int unsigned OFFSET_W    = $clog2(FLASH_BYTES);
  localparam int unsigned END_W       = OFFSET_W + 1;

  // Unlock addresses (matched on the low twelve address bits)
  localparam logic [11:0] ADDR_UNLOCK1 = 12'hAAA;
  localparam logic [11:0] ADDR_UNLOCK2 = 12'h555;

  // Command bytes
  localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
  localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
  localparam logic [7:0] CMD_PROGRAM = 8'hA0;
  localparam logic [7:0] CMD_ERASE   = 8'h80;
  localparam logic [7:0] CMD_RESET   = 8'hF0;
  localparam logic [7:0] CMD_CHIP    = 8'h10;
  localparam logic [7:0] CMD_SECTOR  = 8'h30;

  // Action codes
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_PROGRAM = 2'd1;
  localparam logic [1:0] ACT_ERASE   = 2'd2;

  // Sector map limits (sector = page * 2 + address bit 13)
  localparam logic [5:0] SEC_SMALL_FIRST = 6'd56;
  localparam logic [5:0] SEC_8K_FIRST    = 6'd60;
  localparam logic [5:0] SEC_8K_SECOND   = 6'd61;

  // Fixed erase ranges
  localparam logic [END_W-1:0] CHIP_ERASE_END = END_W'(FLASH_BYTES - PAGE_BYTES);
  localparam logic [END_W-1:0] BLOCK_BYTES    = END_W'(20'h10000);
  localparam logic [OFFSET_W-1:0] SMALL_START = OFFSET_W'(20'h70000);
  localparam logic [END_W-1:0]    SMALL_END   = END_W'(20'h78000);
  localparam logic [OFFSET_W-1:0] SEC60_START = OFFSET_W'(20'h78000);
  localparam logic [END_W-1:0]    SEC60_END   = END_W'(20'h7A000);
  localparam logic [OFFSET_W-1:0] SEC61_START = OFFSET_W'(20'h7A000);
  localparam logic [END_W-1:0]    SEC61_END   = END_W'(20'h7C000);

  // One CPU write to flash space
  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [4:0]  bank_page;
  } cmd_t;

  // One action toward the flash array
  typedef struct packed {
    logic [1:0]          action;
    logic [OFFSET_W-1:0] range_start;
    logic [END_W-1:0]    range_end;
    logic [7:0]          program_byte;
  } act_t;

endpackage

>>> src/flash_command_sequencer_core.sv
// Flash command sequencer: decodes unlock/command writes into program and erase actions.
//
// Usage:
//   cmd channel (cmd_valid, cmd_stall, cmd) carries one CPU write to flash space per beat:
//   address, write data and the flash page mapped into the addressed bank.
//   act channel (act_valid, act_stall, act) returns exactly one action beat per cmd beat:
//   none, program (AND program_byte into flash at range_start) or erase
//   (fill range_start up to range_end, exclusive, with FF).
// Output: the action is registered and appears in the cycle after its write is taken.
// Throughput: one write per cycle outside a stall; the sequence state and the action
//   are formed in one pass of logic and land in the action register at the same edge.
// Stall: while an action waits in the output register under act_stall, cmd_stall
//   is raised and no write is taken; once the action leaves, a new write is taken
//   in that same cycle.
// Reset (rst, synchronous): the sequence returns to idle with the program command
//   selected, and the action register is emptied.
module flash_command_sequencer_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  fcs_pkg::cmd_t cmd,
  output logic          act_valid,
  input  logic          act_stall,
  output fcs_pkg::act_t act
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_UNLOCK  = 6'b000010,
    ST_COMMAND = 6'b000100,
    ST_DATA    = 6'b001000,
    ST_EUNLOCK = 6'b010000,
    ST_ECMD    = 6'b100000
  } seq_state_t;

  seq_state_t         seq_step;
  seq_state_t         seq_step_next;
  logic               erase_mode;
  logic               erase_mode_next;
  fcs_pkg::act_t      act_next;
  logic               cmd_accept;
  logic               at_a;
  logic               at_5;
  logic [5:0]         sector;
  logic [fcs_pkg::OFFSET_W-1:0] block_start;

  // Take a write whenever the action register is free or being drained
  assign cmd_stall  = act_valid && act_stall;
  assign cmd_accept = cmd_valid && !cmd_stall;

  // Decode address match and sector number
  assign at_a   = (cmd.address[11:0] == fcs_pkg::ADDR_UNLOCK1);
  assign at_5   = (cmd.address[11:0] == fcs_pkg::ADDR_UNLOCK2);
  assign sector = {cmd.bank_page, cmd.address[13]};
  assign block_start = {sector[5:3], 16'h0000};

  // Advance the sequence and form the action
  always_comb begin
    seq_step_next   = seq_step;
    erase_mode_next = erase_mode;
    act_next        = '0;
    act_next.action = fcs_pkg::ACT_NONE;
    unique case (seq_step)
      ST_IDLE: begin
        if (at_a && cmd.write_data == fcs_pkg::CMD_UNLOCK1) seq_step_next = ST_UNLOCK;
      end
      ST_UNLOCK: begin
        seq_step_next = (at_5 && cmd.write_data == fcs_pkg::CMD_UNLOCK2) ?
                        ST_COMMAND : ST_IDLE;
      end
      ST_COMMAND: begin
        if (at_a && cmd.write_data == fcs_pkg::CMD_PROGRAM) begin
          erase_mode_next = 1'b0;
          seq_step_next   = ST_DATA;
        end else if (at_a && cmd.write_data == fcs_pkg::CMD_ERASE) begin
          erase_mode_next = 1'b1;
          seq_step_next   = ST_DATA;
        end else begin
          seq_step_next = ST_IDLE;
        end
      end
      ST_DATA: begin
        if (!erase_mode) begin
          act_next.action       = fcs_pkg::ACT_PROGRAM;
          act_next.range_start  = {cmd.bank_page, cmd.address[13:0]};
          act_next.program_byte = cmd.write_data;
          seq_step_next         = ST_IDLE;
        end else if (cmd.write_data == fcs_pkg::CMD_RESET) begin
          seq_step_next = ST_IDLE;
        end else if (at_a && cmd.write_data == fcs_pkg::CMD_UNLOCK1) begin
          seq_step_next = ST_EUNLOCK;
        end
      end
      ST_EUNLOCK: begin
        if (cmd.write_data == fcs_pkg::CMD_RESET) begin
          seq_step_next = ST_IDLE;
        end else if (at_5 && cmd.write_data == fcs_pkg::CMD_UNLOCK2) begin
          seq_step_next = ST_ECMD;
        end
      end
      ST_ECMD: begin
        seq_step_next = ST_IDLE;
        if (at_a && cmd.write_data == fcs_pkg::CMD_CHIP) begin
          act_next.action    = fcs_pkg::ACT_ERASE;
          act_next.range_end = fcs_pkg::CHIP_ERASE_END;
        end else if (cmd.write_data == fcs_pkg::CMD_SECTOR) begin
          priority if (sector < fcs_pkg::SEC_SMALL_FIRST) begin
            act_next.action      = fcs_pkg::ACT_ERASE;
            act_next.range_start = block_start;
            act_next.range_end   = {1'b0, block_start} + fcs_pkg::BLOCK_BYTES;
          end else if (sector < fcs_pkg::SEC_8K_FIRST) begin
            act_next.action      = fcs_pkg::ACT_ERASE;
            act_next.range_start = fcs_pkg::SMALL_START;
            act_next.range_end   = fcs_pkg::SMALL_END;
          end else if (sector == fcs_pkg::SEC_8K_FIRST) begin
            act_next.action      = fcs_pkg::ACT_ERASE;
            act_next.range_start = fcs_pkg::SEC60_START;
            act_next.range_end   = fcs_pkg::SEC60_END;
          end else if (sector == fcs_pkg::SEC_8K_SECOND) begin
            act_next.action      = fcs_pkg::ACT_ERASE;
            act_next.range_start = fcs_pkg::SEC61_START;
            act_next.range_end   = fcs_pkg::SEC61_END;
          end else begin
            // boot sectors are protected
            act_next.action = fcs_pkg::ACT_NONE;
          end
        end
      end
      default: begin
        seq_step_next = ST_IDLE;
      end
    endcase
  end

  // Hold sequence state; advance only on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_step   <= ST_IDLE;
      erase_mode <= 1'b0;
    end else if (cmd_accept) begin
      seq_step   <= seq_step_next;
      erase_mode <= erase_mode_next;
    end
  end

  // Action register: load on accept, hold while stalled, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
    end else begin
      act_valid <= cmd_accept || (act_valid && act_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      act <= act_next;
    end
  end

  // A program write in the data step yields a program action next cycle
  assert property (@(posedge clk) disable iff (rst)
    cmd_accept && seq_step == ST_DATA && !erase_mode |=>
      act_valid && act.action == fcs_pkg::ACT_PROGRAM)
    else $error("program write did not yield a program action");

  // The final step of a sequence always returns to idle
  assert property (@(posedge clk) disable iff (rst)
    cmd_accept && (seq_step == ST_ECMD || (seq_step == ST_DATA && !erase_mode)) |=>
      seq_step == ST_IDLE)
    else $error("sequence did not return to idle after its last write");

  // An erase range is never empty
  assert property (@(posedge clk) disable iff (rst)
    act_valid && act.action == fcs_pkg::ACT_ERASE |->
      act.range_end > {1'b0, act.range_start})
    else $error("empty erase range");

  // Only a program action carries a byte
  assert property (@(posedge clk) disable iff (rst)
    act_valid && act.action != fcs_pkg::ACT_PROGRAM |-> act.program_byte == 8'h00)
    else $error("byte present on a non-program action");

  // A stalled action holds across the stall
  assert property (@(posedge clk) disable iff (rst)
    act_valid && act_stall |=> act_valid && $stable(act))
    else $error("stalled action changed");

endmodule
